>>> sv/qlim_pkg.sv
// Shared types and constants of the four-lane I2C master core.
`default_nettype none
package qlim_pkg;

  localparam int unsigned RX_LANES = 4;
  localparam logic [15:0] DELAY_RESET = 16'd50;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_START   = 3'd1,
    OP_RESTART = 3'd2,
    OP_STOP    = 3'd3,
    OP_WRITE   = 3'd4,
    OP_READ    = 3'd5
  } opcode_t;

  typedef enum logic [4:0] {
    PH_IDLE          = 5'd0,
    PH_RS_HIGH       = 5'd1,
    PH_RS_WAIT       = 5'd2,
    PH_ST_SDA_LOW    = 5'd3,
    PH_ST_WAIT       = 5'd4,
    PH_ST_SCL_LOW    = 5'd5,
    PH_WR_BIT        = 5'd6,
    PH_WR_SCL_HIGH   = 5'd7,
    PH_WR_WAIT       = 5'd8,
    PH_WR_SCL_LOW    = 5'd9,
    PH_WR_RELEASE    = 5'd10,
    PH_WR_PULLUP     = 5'd11,
    PH_WR_ACK_HIGH   = 5'd12,
    PH_WR_ACK_LOW    = 5'd13,
    PH_WR_DRIVE      = 5'd14,
    PH_WR_SDA_LOW    = 5'd15,
    PH_SP_SDA_LOW    = 5'd16,
    PH_SP_WAIT       = 5'd17,
    PH_SP_SCL_HIGH   = 5'd18,
    PH_SP_SDA_HIGH   = 5'd19,
    PH_RD_PULLUP     = 5'd20,
    PH_RD_RELEASE    = 5'd21,
    PH_RD_WAIT       = 5'd22,
    PH_RD_SCL_HIGH   = 5'd23,
    PH_RD_SAMPLE_LOW = 5'd24,
    PH_RD_DRIVE      = 5'd25,
    PH_RD_ACK_BIT    = 5'd26,
    PH_RD_ACK_HIGH   = 5'd27,
    PH_RD_ACK_WAIT   = 5'd28,
    PH_RD_ACK_LOW    = 5'd29,
    PH_RD_SDA_LOW    = 5'd30
  } phase_t;

  // Stop sequence steps held in bit_count while waiting.
  localparam logic [3:0] SP_STEP_SCL = 4'd0;
  localparam logic [3:0] SP_STEP_SDA = 4'd1;
  localparam logic [3:0] SP_STEP_END = 4'd2;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  bit_count;
    logic [15:0] wait_count;
    logic [7:0]  send_shift;
    logic        clock_line;
    logic        data_line;
    logic        data_enable;
    logic        nak_flag;
    logic        ack_flag;
  } seq_state_t;

  // Packed so that the last field sits in the lowest bits.
  typedef struct packed {
    logic [7:0] rx_lane4;
    logic [7:0] rx_lane3;
    logic [7:0] rx_lane2;
    logic [7:0] rx_lane1;
    logic       ack_received;
    logic       done_res;
    logic       busy_res;
    logic       sda_output_enable;
    logic       sda_level;
    logic       scl_level;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage
`default_nettype wire

>>> sv/quad_lane_i2c_master_core.sv
// Each result is registered in the output buffer before it appears on out_*.
// Throughput: one input transaction per cycle unless the skid stage is full; the
// sequencer state register is updated in a single pass, and the skid stage lets
// input continue while a result waits. Each bus pin change costs one input, each
// delay point delay_ticks inputs, one if zero. Reset (synchronous, rst_n low): idle,
// both lines released high, data driven, delay_ticks back to 50, output buffer empty.
`default_nettype none
module quad_lane_i2c_master_core #(
  parameter int NUM_LANES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // tx_byte[7:0], nak_after_read[8], sda_in[12:9]
  input  wire logic [2:0]  in_tuser,  // opcode[2:0]
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // scl_level[0], sda_level[1], sda_output_enable[2], busy_res[3], done_res[4],
  // ack_received[5], rx_lane1[13:6], rx_lane2[21:14], rx_lane3[29:22],
  // rx_lane4[37:30]
  output logic [qlim_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [15:0]       delay_ticks_r;
  logic              cfg_sel_delay;
  logic              step;
  qlim_pkg::result_t seq_result;
  qlim_pkg::result_t out_result;

  // Only the delay register exists, seen at addresses 0 to 3; addresses 4 to 7 lie beyond the register list.
  assign cfg_pready    = 1'b1;
  assign cfg_sel_delay = ~cfg_paddr[2];
  assign cfg_prdata    = cfg_sel_delay ? {16'd0, delay_ticks_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_ticks_r <= qlim_pkg::DELAY_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_delay) begin
      delay_ticks_r <= cfg_pwdata[15:0];
    end
  end

  assign step = in_tvalid & in_tready;

  qlim_seq #(
    .NUM_LANES(NUM_LANES)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .opcode        (in_tuser),
    .tx_byte       (in_tdata[7:0]),
    .nak_after_read(in_tdata[8]),
    .sda_in        (in_tdata[12:9]),
    .delay_ticks   (delay_ticks_r),
    .result        (seq_result)
  );

  qlim_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(in_tvalid),
    .push_ready(in_tready),
    .push_data (seq_result),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (out_result)
  );

  assign out_tdata = {{(qlim_pkg::OUT_DATA_W - qlim_pkg::RESULT_W){1'b0}}, out_result};

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted transaction produced no result");

  a_full_means_presenting: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("skid stage occupied while output register is empty");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_result.done_res) |-> !out_result.busy_res)
    else $error("sequence reported done while still busy");

endmodule
`default_nettype wire

>>> sv/qlim_seq.sv
// Bus sequencer: state registers and the single-tick next-state logic.
`default_nettype none
module qlim_seq #(
  parameter int NUM_LANES = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [2:0]          opcode,
  input  wire logic [7:0]          tx_byte,
  input  wire logic                nak_after_read,
  input  wire logic [3:0]          sda_in,
  input  wire logic [15:0]         delay_ticks,
  output qlim_pkg::result_t        result
);

  qlim_pkg::seq_state_t st_r, st_nxt, st_ld;
  logic [7:0] rx_r   [NUM_LANES];
  logic [7:0] rx_nxt [NUM_LANES];
  logic [7:0] rx_pad [qlim_pkg::RX_LANES];
  logic [NUM_LANES+3:0] sda_wide;
  logic [15:0] limit;
  logic [15:0] wait_inc;
  logic        wait_hit;
  logic [3:0]  bit_inc;
  logic        done;

  assign sda_wide = {{NUM_LANES{1'b0}}, sda_in};
  assign limit    = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;

  always_comb begin
    st_ld = st_r;
    if (st_r.phase == qlim_pkg::PH_IDLE &&
        opcode >= 3'(qlim_pkg::OP_START) && opcode <= 3'(qlim_pkg::OP_READ)) begin
      st_ld.send_shift = tx_byte;
      st_ld.nak_flag   = nak_after_read;
      st_ld.bit_count  = 4'd0;
      st_ld.wait_count = 16'd0;
      case (qlim_pkg::opcode_t'(opcode))
        qlim_pkg::OP_START:   st_ld.phase = qlim_pkg::PH_ST_SDA_LOW;
        qlim_pkg::OP_RESTART: st_ld.phase = qlim_pkg::PH_RS_HIGH;
        qlim_pkg::OP_STOP:    st_ld.phase = qlim_pkg::PH_SP_SDA_LOW;
        qlim_pkg::OP_WRITE:   st_ld.phase = qlim_pkg::PH_WR_BIT;
        default:              st_ld.phase = qlim_pkg::PH_RD_PULLUP;
      endcase
    end
  end

  assign wait_inc = st_ld.wait_count + 16'd1;
  assign wait_hit = wait_inc >= limit;
  assign bit_inc  = st_ld.bit_count + 4'd1;

  always_comb begin
    st_nxt = st_ld;
    rx_nxt = rx_r;
    done   = 1'b0;
    case (st_ld.phase)
      qlim_pkg::PH_IDLE: ;
      qlim_pkg::PH_RS_HIGH: begin
        st_nxt.clock_line = 1'b1;
        st_nxt.data_line  = 1'b1;
        st_nxt.phase      = qlim_pkg::PH_RS_WAIT;
      end
      qlim_pkg::PH_RS_WAIT, qlim_pkg::PH_ST_WAIT, qlim_pkg::PH_WR_WAIT,
      qlim_pkg::PH_RD_WAIT, qlim_pkg::PH_RD_ACK_WAIT, qlim_pkg::PH_SP_WAIT: begin
        st_nxt.wait_count = wait_hit ? 16'd0 : wait_inc;
        if (wait_hit) begin
          case (st_ld.phase)
            qlim_pkg::PH_RS_WAIT:     st_nxt.phase = qlim_pkg::PH_ST_SDA_LOW;
            qlim_pkg::PH_ST_WAIT:     st_nxt.phase = qlim_pkg::PH_ST_SCL_LOW;
            qlim_pkg::PH_WR_WAIT:     st_nxt.phase = qlim_pkg::PH_WR_SCL_LOW;
            qlim_pkg::PH_RD_WAIT:     st_nxt.phase = qlim_pkg::PH_RD_SCL_HIGH;
            qlim_pkg::PH_RD_ACK_WAIT: st_nxt.phase = qlim_pkg::PH_RD_ACK_LOW;
            default: begin
              if (st_ld.bit_count == qlim_pkg::SP_STEP_SCL) begin
                st_nxt.phase = qlim_pkg::PH_SP_SCL_HIGH;
              end else if (st_ld.bit_count == qlim_pkg::SP_STEP_SDA) begin
                st_nxt.phase = qlim_pkg::PH_SP_SDA_HIGH;
              end else begin
                st_nxt.phase = qlim_pkg::PH_IDLE;
                done         = 1'b1;
              end
            end
          endcase
        end
      end
      qlim_pkg::PH_ST_SDA_LOW: begin
        st_nxt.data_line = 1'b0;
        st_nxt.phase     = qlim_pkg::PH_ST_WAIT;
      end
      qlim_pkg::PH_ST_SCL_LOW: begin
        st_nxt.clock_line = 1'b0;
        st_nxt.bit_count  = 4'd0;
        st_nxt.phase      = qlim_pkg::PH_WR_BIT;
      end
      qlim_pkg::PH_WR_BIT: begin
        st_nxt.data_line = |(st_ld.send_shift & qlim_pkg::MSB_MASK);
        st_nxt.phase     = qlim_pkg::PH_WR_SCL_HIGH;
      end
      qlim_pkg::PH_WR_SCL_HIGH: begin
        st_nxt.clock_line = 1'b1;
        st_nxt.phase      = qlim_pkg::PH_WR_WAIT;
      end
      qlim_pkg::PH_WR_SCL_LOW: begin
        st_nxt.clock_line = 1'b0;
        st_nxt.send_shift = {st_ld.send_shift[6:0], 1'b0} & qlim_pkg::BYTE_MASK;
        st_nxt.bit_count  = bit_inc;
        st_nxt.phase      = (bit_inc >= qlim_pkg::BITS_PER_BYTE) ?
                            qlim_pkg::PH_WR_RELEASE : qlim_pkg::PH_WR_BIT;
      end
      qlim_pkg::PH_WR_RELEASE: begin
        st_nxt.data_enable = 1'b0;
        st_nxt.phase       = qlim_pkg::PH_WR_PULLUP;
      end
      qlim_pkg::PH_WR_PULLUP: begin
        st_nxt.data_line = 1'b1;
        st_nxt.phase     = qlim_pkg::PH_WR_ACK_HIGH;
      end
      qlim_pkg::PH_WR_ACK_HIGH: begin
        st_nxt.clock_line = 1'b1;
        st_nxt.phase      = qlim_pkg::PH_WR_ACK_LOW;
      end
      qlim_pkg::PH_WR_ACK_LOW: begin
        // Only lane 1 reports the acknowledge.
        st_nxt.ack_flag   = ~sda_in[0];
        st_nxt.clock_line = 1'b0;
        st_nxt.phase      = qlim_pkg::PH_WR_DRIVE;
      end
      qlim_pkg::PH_WR_DRIVE: begin
        st_nxt.data_enable = 1'b1;
        st_nxt.phase       = qlim_pkg::PH_WR_SDA_LOW;
      end
      qlim_pkg::PH_WR_SDA_LOW, qlim_pkg::PH_RD_SDA_LOW: begin
        st_nxt.data_line = 1'b0;
        st_nxt.phase     = qlim_pkg::PH_IDLE;
        done             = 1'b1;
      end
      qlim_pkg::PH_SP_SDA_LOW: begin
        st_nxt.data_line = 1'b0;
        st_nxt.bit_count = qlim_pkg::SP_STEP_SCL;
        st_nxt.phase     = qlim_pkg::PH_SP_WAIT;
      end
      qlim_pkg::PH_SP_SCL_HIGH: begin
        st_nxt.clock_line = 1'b1;
        st_nxt.bit_count  = qlim_pkg::SP_STEP_SDA;
        st_nxt.phase      = qlim_pkg::PH_SP_WAIT;
      end
      qlim_pkg::PH_SP_SDA_HIGH: begin
        st_nxt.data_line = 1'b1;
        st_nxt.bit_count = qlim_pkg::SP_STEP_END;
        st_nxt.phase     = qlim_pkg::PH_SP_WAIT;
      end
      qlim_pkg::PH_RD_PULLUP: begin
        st_nxt.data_line = 1'b1;
        st_nxt.phase     = qlim_pkg::PH_RD_RELEASE;
      end
      qlim_pkg::PH_RD_RELEASE: begin
        st_nxt.data_enable = 1'b0;
        st_nxt.bit_count   = 4'd0;
        st_nxt.phase       = qlim_pkg::PH_RD_WAIT;
      end
      qlim_pkg::PH_RD_SCL_HIGH: begin
        st_nxt.clock_line = 1'b1;
        st_nxt.phase      = qlim_pkg::PH_RD_SAMPLE_LOW;
      end
      qlim_pkg::PH_RD_SAMPLE_LOW: begin
        // Lanes beyond the four sampled lines shift in zero.
        for (int i = 0; i < NUM_LANES; i++) begin
          rx_nxt[i] = {rx_r[i][6:0], sda_wide[i]};
        end
        st_nxt.clock_line = 1'b0;
        st_nxt.bit_count  = bit_inc;
        st_nxt.phase      = (bit_inc >= qlim_pkg::BITS_PER_BYTE) ?
                            qlim_pkg::PH_RD_DRIVE : qlim_pkg::PH_RD_WAIT;
      end
      qlim_pkg::PH_RD_DRIVE: begin
        st_nxt.data_enable = 1'b1;
        st_nxt.phase       = qlim_pkg::PH_RD_ACK_BIT;
      end
      qlim_pkg::PH_RD_ACK_BIT: begin
        st_nxt.data_line = st_ld.nak_flag;
        st_nxt.phase     = qlim_pkg::PH_RD_ACK_HIGH;
      end
      qlim_pkg::PH_RD_ACK_HIGH: begin
        st_nxt.clock_line = 1'b1;
        st_nxt.phase      = qlim_pkg::PH_RD_ACK_WAIT;
      end
      qlim_pkg::PH_RD_ACK_LOW: begin
        st_nxt.clock_line = 1'b0;
        st_nxt.phase      = qlim_pkg::PH_RD_SDA_LOW;
      end
      default: st_nxt.phase = qlim_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= qlim_pkg::PH_IDLE;
      st_r.bit_count   <= 4'd0;
      st_r.wait_count  <= 16'd0;
      st_r.send_shift  <= 8'd0;
      st_r.clock_line  <= 1'b1;
      st_r.data_line   <= 1'b1;
      st_r.data_enable <= 1'b1;
      st_r.nak_flag    <= 1'b0;
      st_r.ack_flag    <= 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        rx_r[i] <= 8'd0;
      end
    end else if (step) begin
      st_r <= st_nxt;
      rx_r <= rx_nxt;
    end
  end

  for (genvar g = 0; g < qlim_pkg::RX_LANES; g++) begin : g_rx
    if (g < NUM_LANES) begin : g_lane
      assign rx_pad[g] = rx_nxt[g];
    end else begin : g_zero
      assign rx_pad[g] = 8'd0;
    end
  end

  always_comb begin
    result.scl_level         = st_nxt.clock_line;
    result.sda_level         = st_nxt.data_line;
    result.sda_output_enable = st_nxt.data_enable;
    result.busy_res          = (st_nxt.phase != qlim_pkg::PH_IDLE);
    result.done_res          = done;
    result.ack_received      = st_nxt.ack_flag;
    result.rx_lane1          = rx_pad[0];
    result.rx_lane2          = rx_pad[1];
    result.rx_lane3          = rx_pad[2];
    result.rx_lane4          = rx_pad[3];
  end

endmodule
`default_nettype wire

>>> sv/qlim_skid.sv
// Two-entry output buffer: result register plus a skid stage.
`default_nettype none
module qlim_skid (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire qlim_pkg::result_t push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output qlim_pkg::result_t      pop_data
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  qlim_pkg::result_t out_data_r, out_data_nxt;
  qlim_pkg::result_t skid_data_r, skid_data_nxt;
  logic              push, pop;

  assign push_ready = ~skid_valid_r;
  assign push       = push_valid & push_ready;
  assign pop        = out_valid_r & pop_ready;
  assign pop_valid  = out_valid_r;
  assign pop_data   = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      out_valid_nxt  = skid_valid_r | push;
      out_data_nxt   = skid_valid_r ? skid_data_r : push_data;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      // Output stalled: park the new transaction in the skid stage.
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
`default_nettype wire

>>> dv/quad_lane_i2c_master_core_test.sv
// Self-checking testbench of the four-lane I2C master core: a per-tick model against the RTL.
`timescale 1ns / 100ps
module quad_lane_i2c_master_core_test;
  import qlim_pkg::*;

  localparam logic [2:0] DELAY_ADDR = 3'd0;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       nak_after_read;
    logic [3:0] sda_in;
  } tick_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic [2:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [2:0]            cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  quad_lane_i2c_master_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  tick_item_t tick_q[$];
  result_t    pending_pins[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         err_count = 0;
  int         gen_count = 0;
  int         gen_delay = 50;

  // Model copy of the sequencer and its delay register.
  logic [15:0] pr_delay;
  phase_t      pr_phase;
  logic [3:0]  pr_bits;
  logic [15:0] pr_wait;
  logic [7:0]  pr_send;
  logic [7:0]  pr_rx [RX_LANES];
  logic        pr_scl, pr_sda, pr_oe, pr_nak, pr_ack;

  function automatic bit delay_point_elapsed();
    pr_wait = pr_wait + 16'd1;
    if (pr_wait >= ((pr_delay == 16'd0) ? 16'd1 : pr_delay)) begin
      pr_wait = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t sequencer_step(input logic [2:0] op, input logic [7:0] tx,
                                             input logic nak, input logic [3:0] sda);
    result_t r;
    logic    done;
    done = 1'b0;
    if (pr_phase == PH_IDLE && op >= OP_START && op <= OP_READ) begin
      pr_send = tx;
      pr_nak  = nak;
      pr_bits = '0;
      pr_wait = '0;
      case (op)
        OP_START:   pr_phase = PH_ST_SDA_LOW;
        OP_RESTART: pr_phase = PH_RS_HIGH;
        OP_STOP:    pr_phase = PH_SP_SDA_LOW;
        OP_WRITE:   pr_phase = PH_WR_BIT;
        default:    pr_phase = PH_RD_PULLUP;
      endcase
    end
    case (pr_phase)
      PH_IDLE: ;
      PH_RS_HIGH: begin
        pr_scl = 1'b1;
        pr_sda = 1'b1;
        pr_phase = PH_RS_WAIT;
      end
      PH_RS_WAIT: if (delay_point_elapsed()) pr_phase = PH_ST_SDA_LOW;
      PH_ST_SDA_LOW: begin
        pr_sda = 1'b0;
        pr_phase = PH_ST_WAIT;
      end
      PH_ST_WAIT: if (delay_point_elapsed()) pr_phase = PH_ST_SCL_LOW;
      PH_ST_SCL_LOW: begin
        pr_scl = 1'b0;
        pr_bits = '0;
        pr_phase = PH_WR_BIT;
      end
      PH_WR_BIT: begin
        pr_sda = pr_send[7];
        pr_phase = PH_WR_SCL_HIGH;
      end
      PH_WR_SCL_HIGH: begin
        pr_scl = 1'b1;
        pr_phase = PH_WR_WAIT;
      end
      PH_WR_WAIT: if (delay_point_elapsed()) pr_phase = PH_WR_SCL_LOW;
      PH_WR_SCL_LOW: begin
        pr_scl = 1'b0;
        pr_send = pr_send << 1;
        pr_bits = pr_bits + 4'd1;
        pr_phase = (pr_bits >= BITS_PER_BYTE) ? PH_WR_RELEASE : PH_WR_BIT;
      end
      PH_WR_RELEASE: begin
        pr_oe = 1'b0;
        pr_phase = PH_WR_PULLUP;
      end
      PH_WR_PULLUP: begin
        pr_sda = 1'b1;
        pr_phase = PH_WR_ACK_HIGH;
      end
      PH_WR_ACK_HIGH: begin
        pr_scl = 1'b1;
        pr_phase = PH_WR_ACK_LOW;
      end
      PH_WR_ACK_LOW: begin
        // Only lane 1 decides the acknowledge.
        pr_ack = ~sda[0];
        pr_scl = 1'b0;
        pr_phase = PH_WR_DRIVE;
      end
      PH_WR_DRIVE: begin
        pr_oe = 1'b1;
        pr_phase = PH_WR_SDA_LOW;
      end
      PH_WR_SDA_LOW: begin
        pr_sda = 1'b0;
        pr_phase = PH_IDLE;
        done = 1'b1;
      end
      PH_SP_SDA_LOW: begin
        pr_sda = 1'b0;
        pr_bits = SP_STEP_SCL;
        pr_phase = PH_SP_WAIT;
      end
      PH_SP_WAIT: begin
        if (delay_point_elapsed()) begin
          if (pr_bits == SP_STEP_SCL) pr_phase = PH_SP_SCL_HIGH;
          else if (pr_bits == SP_STEP_SDA) pr_phase = PH_SP_SDA_HIGH;
          else begin
            pr_phase = PH_IDLE;
            done = 1'b1;
          end
        end
      end
      PH_SP_SCL_HIGH: begin
        pr_scl = 1'b1;
        pr_bits = SP_STEP_SDA;
        pr_phase = PH_SP_WAIT;
      end
      PH_SP_SDA_HIGH: begin
        pr_sda = 1'b1;
        pr_bits = SP_STEP_END;
        pr_phase = PH_SP_WAIT;
      end
      PH_RD_PULLUP: begin
        pr_sda = 1'b1;
        pr_phase = PH_RD_RELEASE;
      end
      PH_RD_RELEASE: begin
        pr_oe = 1'b0;
        pr_bits = '0;
        pr_phase = PH_RD_WAIT;
      end
      PH_RD_WAIT: if (delay_point_elapsed()) pr_phase = PH_RD_SCL_HIGH;
      PH_RD_SCL_HIGH: begin
        pr_scl = 1'b1;
        pr_phase = PH_RD_SAMPLE_LOW;
      end
      PH_RD_SAMPLE_LOW: begin
        for (int i = 0; i < RX_LANES; i++)
          pr_rx[i] = {pr_rx[i][6:0], (i < 4) ? sda[i] : 1'b0};
        pr_scl = 1'b0;
        pr_bits = pr_bits + 4'd1;
        pr_phase = (pr_bits >= BITS_PER_BYTE) ? PH_RD_DRIVE : PH_RD_WAIT;
      end
      PH_RD_DRIVE: begin
        pr_oe = 1'b1;
        pr_phase = PH_RD_ACK_BIT;
      end
      PH_RD_ACK_BIT: begin
        pr_sda = pr_nak;
        pr_phase = PH_RD_ACK_HIGH;
      end
      PH_RD_ACK_HIGH: begin
        pr_scl = 1'b1;
        pr_phase = PH_RD_ACK_WAIT;
      end
      PH_RD_ACK_WAIT: if (delay_point_elapsed()) pr_phase = PH_RD_ACK_LOW;
      PH_RD_ACK_LOW: begin
        pr_scl = 1'b0;
        pr_phase = PH_RD_SDA_LOW;
      end
      PH_RD_SDA_LOW: begin
        pr_sda = 1'b0;
        pr_phase = PH_IDLE;
        done = 1'b1;
      end
      default: pr_phase = PH_IDLE;
    endcase
    r.scl_level         = pr_scl;
    r.sda_level         = pr_sda;
    r.sda_output_enable = pr_oe;
    r.busy_res          = (pr_phase != PH_IDLE);
    r.done_res          = done;
    r.ack_received      = pr_ack;
    r.rx_lane1          = pr_rx[0];
    r.rx_lane2          = pr_rx[1];
    r.rx_lane3          = pr_rx[2];
    r.rx_lane4          = pr_rx[3];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= 10)
        $display("%0t: %s expected %0h got %0h", $realtime, name, want, got);
    end
  endtask

  // Input driver: one queued tick per transaction, with random gaps.
  always @(posedge clk) begin : tick_driver
    tick_item_t tk;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        tk = tick_q.pop_front();
        in_tdata  <= {3'b000, tk.sda_in, tk.nak_after_read, tk.tx_byte};
        in_tuser  <= tk.opcode;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : pin_monitor
    result_t want;
    result_t got;
    if (!rst_n) begin
      pr_delay = DELAY_RESET;
      pr_phase = PH_IDLE;
      pr_bits  = '0;
      pr_wait  = '0;
      pr_send  = '0;
      for (int i = 0; i < RX_LANES; i++) pr_rx[i] = '0;
      pr_scl = 1'b1;
      pr_sda = 1'b1;
      pr_oe  = 1'b1;
      pr_nak = 1'b0;
      pr_ack = 1'b0;
      pending_pins.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == DELAY_ADDR)
        pr_delay = cfg_pwdata[15:0];
      if (in_tvalid && in_tready)
        pending_pins.push_back(sequencer_step(in_tuser, in_tdata[7:0], in_tdata[8],
                                              in_tdata[12:9]));
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[RESULT_W-1:0]);
        if (pending_pins.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("%0t: unexpected result %h", $realtime, got);
        end else begin
          want = pending_pins.pop_front();
          check_field("scl_level", want.scl_level, got.scl_level);
          check_field("sda_level", want.sda_level, got.sda_level);
          check_field("sda_output_enable", want.sda_output_enable, got.sda_output_enable);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("ack_received", want.ack_received, got.ack_received);
          check_field("rx_lane1", want.rx_lane1, got.rx_lane1);
          check_field("rx_lane2", want.rx_lane2, got.rx_lane2);
          check_field("rx_lane3", want.rx_lane3, got.rx_lane3);
          check_field("rx_lane4", want.rx_lane4, got.rx_lane4);
        end
      end
    end
  end

  // Ticks that a command keeps the sequencer busy, its own tick included.
  function automatic int cmd_ticks(input logic [2:0] op, input int d);
    int e;
    int wr;
    e  = (d == 0) ? 1 : d;
    wr = 8 * (3 + e) + 6;
    case (op)
      OP_START:   return 2 + e + wr;
      OP_RESTART: return 3 + 2 * e + wr;
      OP_STOP:    return 3 + 3 * e;
      OP_WRITE:   return wr;
      OP_READ:    return 7 + 8 * (e + 2) + e;
      default:    return 1;
    endcase
  endfunction

  // Queues a command tick and the idle ticks that carry it through; slack shortens
  // or stretches the run so that later commands may land while still busy.
  task automatic add_cmd(input logic [2:0] op, input logic [7:0] tx, input logic nak,
                         input int sda_fix, input int slack, input bit noisy);
    tick_item_t tk;
    int         fill;
    fill = cmd_ticks(op, gen_delay) - 1 + slack;
    tk.opcode = op;
    tk.tx_byte = tx;
    tk.nak_after_read = nak;
    tk.sda_in = (sda_fix < 0) ? 4'($urandom) : 4'(sda_fix);
    tick_q.push_back(tk);
    gen_count++;
    for (int i = 0; i < fill; i++) begin
      tk.opcode = OP_NONE;
      if (noisy && $urandom_range(99) < 6) tk.opcode = 3'($urandom_range(1, 7));
      tk.tx_byte = 8'($urandom);
      tk.nak_after_read = 1'($urandom);
      tk.sda_in = (sda_fix < 0) ? 4'($urandom) : 4'(sda_fix);
      tick_q.push_back(tk);
      gen_count++;
    end
  endtask

  task automatic write_delay(input logic [15:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= DELAY_ADDR;
    cfg_pwdata  <= {16'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    gen_delay = value;
  endtask

  task automatic wait_quiet();
    while (tick_q.size() != 0 || in_tvalid || pending_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : sequencer_test
    int send_pct [4] = '{0, 45, 0, 30};
    int recv_pct [4] = '{0, 0, 45, 30};
    int delays   [4];
    int target;
    int r;
    int slack;
    delays = '{2, 1, $urandom_range(3, 6), $urandom_range(1, 4)};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // A full stop sequence at the reset delay.
    add_cmd(OP_STOP, 8'h00, 1'b0, -1, 0, 1'b0);
    wait_quiet();

    // A delay of zero behaves as one tick per delay point.
    write_delay(16'd0);
    add_cmd(OP_START, 8'hFF, 1'b0, 4'hF, 0, 1'b0);
    add_cmd(OP_WRITE, 8'h00, 1'b1, 4'h0, 0, 1'b0);
    add_cmd(OP_READ, 8'h3C, 1'b0, 4'hF, 0, 1'b0);
    add_cmd(OP_READ, 8'hC3, 1'b1, 4'h0, 0, 1'b0);
    add_cmd(OP_RESTART, 8'h81, 1'b0, -1, 0, 1'b0);
    add_cmd(OP_READ, 8'($urandom), 1'b0, -1, 0, 1'b0);
    add_cmd(3'd6, 8'hFF, 1'b1, 4'hF, 0, 1'b0);
    add_cmd(3'd7, 8'h00, 1'b0, 4'h0, 0, 1'b0);
    add_cmd(OP_NONE, 8'hAA, 1'b1, -1, 0, 1'b0);
    // The second write arrives while the first is still running and is dropped.
    add_cmd(OP_WRITE, 8'h5A, 1'b0, -1, -4, 1'b0);
    add_cmd(OP_WRITE, 8'hA5, 1'b0, -1, 0, 1'b0);
    add_cmd(OP_STOP, 8'h00, 1'b1, -1, 0, 1'b0);
    add_cmd(OP_WRITE, 8'hFF, 1'b1, -1, 0, 1'b0);
    // Leave a stop sequence parked inside a delay point.
    add_cmd(OP_STOP, 8'h00, 1'b0, -1, -3, 1'b0);
    wait_quiet();

    // The longest delay keeps it parked; the next, shorter one releases it at once.
    // Only forty ticks are sent while parked.
    write_delay(16'hFFFF);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    add_cmd(OP_WRITE, 8'h96, 1'b1, -1, 40 - cmd_ticks(OP_WRITE, gen_delay), 1'b1);
    wait_quiet();

    for (int ph = 0; ph < 4; ph++) begin
      write_delay(16'(delays[ph]));
      send_idle_pct = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      target = gen_count + 280;
      add_cmd(OP_NONE, 8'h00, 1'b0, -1, 6, 1'b0);
      while (gen_count < target) begin
        r = $urandom_range(99);
        slack = (r < 80) ? 0 : (r < 90) ? -int'($urandom_range(1, 6)) : $urandom_range(1, 4);
        add_cmd(3'($urandom_range(OP_START, OP_READ)), 8'($urandom), 1'($urandom), -1,
                slack, 1'b1);
      end
      wait_quiet();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0 && pending_pins.size() == 0) begin
      $display("quad_lane_i2c_master_core test passed");
    end else begin
      $display("quad_lane_i2c_master_core test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("quad_lane_i2c_master_core test failed");
    $finish;
  end

endmodule

>>> sim.f
sv/qlim_pkg.sv
sv/qlim_seq.sv
sv/qlim_skid.sv
sv/quad_lane_i2c_master_core.sv
dv/quad_lane_i2c_master_core_test.sv
